// ----- src/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the BMP encoding function for the UTF-16 to
// UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int CU_W        = 16;
  localparam int BYTE_W      = 8;
  localparam int HELD_W      = 10;
  localparam int MAX_BYTES   = 6;
  localparam int CNT_W       = 3;

  localparam logic [CU_W-1:0]   MAX_UNITS_RST = 16'd256;
  localparam logic [CU_W-1:0]   INDEX_SAT     = 16'hFFFF;
  localparam logic [CU_W-1:0]   REPL_CHAR     = 16'hFFFD;
  localparam logic [5:0]        HIGH_TAG      = 6'b110110;
  localparam logic [5:0]        LOW_TAG       = 6'b110111;
  localparam logic [BYTE_W-1:0] DOT_BYTE      = 8'h2E;
  localparam logic [20:0]       SUPP_BASE     = 21'h10000;

  typedef struct packed {
    logic              high_pending;
    logic [HELD_W-1:0] held_high;
    logic [CU_W-1:0]   unit_index;
  } u16u8_state_t;

  typedef struct packed {
    logic [CNT_W-1:0]                    count;
    logic [MAX_BYTES-1:0][BYTE_W-1:0]    bytes;  // bytes[0] goes out first
  } u16u8_burst_t;

  typedef struct packed {
    logic [1:0]              len;
    logic [2:0][BYTE_W-1:0]  b;
  } u16u8_seq_t;

  // One to three byte UTF-8 form of a code point below 0x10000
  function automatic u16u8_seq_t enc_bmp(input logic [CU_W-1:0] cp);
    u16u8_seq_t s;
    s = '0;
    if (cp[15:7] == 9'd0) begin
      s.len  = 2'd1;
      s.b[0] = {1'b0, cp[6:0]};
    end else if (cp[15:11] == 5'd0) begin
      s.len  = 2'd2;
      s.b[0] = {3'b110, cp[10:6]};
      s.b[1] = {2'b10, cp[5:0]};
    end else begin
      s.len  = 2'd3;
      s.b[0] = {4'b1110, cp[15:12]};
      s.b[1] = {2'b10, cp[11:6]};
      s.b[2] = {2'b10, cp[5:0]};
    end
    return s;
  endfunction

endpackage

// ----- src/u16u8_in_if.sv -----
// ----------------------------------------------------------------------------
// u16u8_in_if
// Code unit channel: valid/ready handshake with one UTF-16 unit per item.
// ----------------------------------------------------------------------------
interface u16u8_in_if
  import u16u8_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CU_W-1:0] code_unit;
  logic            last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

// ----- src/u16u8_out_if.sv -----
// ----------------------------------------------------------------------------
// u16u8_out_if
// Byte channel: valid/ready handshake with one UTF-8 byte per item.
// ----------------------------------------------------------------------------
interface u16u8_out_if
  import u16u8_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] utf8_byte;
  logic              last_of_item;
  logic              end_of_text;

  modport source (output valid, output utf8_byte, output last_of_item,
                  output end_of_text, input ready);
  modport sink   (input valid, input utf8_byte, input last_of_item,
                  input end_of_text, output ready);
endinterface

// ----- src/u16u8_encode.sv -----
// ----------------------------------------------------------------------------
// u16u8_encode
// Turns one code unit plus the surrogate/limit state into a burst of up to
// six UTF-8 bytes and the state that follows.
// ----------------------------------------------------------------------------
module u16u8_encode
  import u16u8_pkg::*;
(
  input  logic [CU_W-1:0] code_unit,
  input  logic            last_unit,
  input  logic [CU_W-1:0] max_units,
  input  u16u8_state_t    st,
  output u16u8_state_t    st_nxt,
  output u16u8_burst_t    burst
);

  logic        accepted;
  logic        is_high;
  logic        is_low;
  logic        pair;
  logic        flush;
  logic        room_next;
  logic        hold;
  logic        emit_b;
  logic        dots;
  logic [20:0] pair_cp;
  logic [CU_W-1:0] cp_b;
  u16u8_seq_t  seq_b;
  u16u8_seq_t  seq_repl;
  logic [CNT_W-1:0] len_b;

  assign accepted  = st.unit_index < max_units;
  assign is_high   = code_unit[15:10] == HIGH_TAG;
  assign is_low    = code_unit[15:10] == LOW_TAG;
  assign pair      = st.high_pending && accepted && is_low;
  assign flush     = st.high_pending && !pair;
  assign room_next = ({1'b0, st.unit_index} + 17'd1) < {1'b0, max_units};
  // hold a high surrogate only while a partner can still fit
  assign hold      = !pair && accepted && is_high && !last_unit && room_next;
  assign emit_b    = !pair && accepted && !hold;
  assign dots      = !pair && !accepted && last_unit;

  assign pair_cp   = {1'b0, st.held_high, code_unit[9:0]} + SUPP_BASE;
  assign cp_b      = (is_high || is_low) ? REPL_CHAR : code_unit;
  assign seq_b     = enc_bmp(cp_b);
  assign seq_repl  = enc_bmp(REPL_CHAR);
  assign len_b     = emit_b ? {1'b0, seq_b.len} : (dots ? 3'd3 : 3'd0);

  always_comb begin
    burst = '0;
    if (pair) begin
      burst.count    = 3'd4;
      burst.bytes[0] = {5'b11110, pair_cp[20:18]};
      burst.bytes[1] = {2'b10, pair_cp[17:12]};
      burst.bytes[2] = {2'b10, pair_cp[11:6]};
      burst.bytes[3] = {2'b10, pair_cp[5:0]};
    end else begin
      if (dots) begin
        burst.bytes[2:0] = {DOT_BYTE, DOT_BYTE, DOT_BYTE};
      end else begin
        burst.bytes[2:0] = seq_b.b;
      end
      if (flush) begin
        // held surrogate went unpaired: replacement first, then this unit
        burst.bytes[5:3] = burst.bytes[2:0];
        burst.bytes[2:0] = seq_repl.b;
        burst.count      = len_b + 3'd3;
      end else begin
        burst.count      = len_b;
      end
    end
  end

  always_comb begin
    st_nxt.high_pending = hold;
    st_nxt.held_high    = hold ? code_unit[HELD_W-1:0] : '0;
    if (last_unit) begin
      st_nxt.unit_index = '0;
    end else if (st.unit_index != INDEX_SAT) begin
      st_nxt.unit_index = st.unit_index + 16'd1;
    end else begin
      st_nxt.unit_index = st.unit_index;
    end
  end

endmodule

// ----- src/utf16_to_utf8_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// The first byte of an item is valid in the cycle after the item is taken.
// Pacing: up to six bytes per item; the byte-wide output shift register sets
//   the pace. Items giving no bytes pass at one per cycle. The next item is
//   taken as the last byte leaves.
// Reset (rst_n low, synchronous): no surrogate held, index zero, limit 256,
//   output buffer empty.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  u16u8_in_if.sink          in_ch,
  u16u8_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [CU_W-1:0]   cfg_wdata
);

  logic [CU_W-1:0]                  max_units_r;
  u16u8_state_t                     st_r;
  u16u8_state_t                     st_nxt;
  u16u8_burst_t                     burst;
  logic [MAX_BYTES-1:0][BYTE_W-1:0] buf_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic                             last_r;
  logic                             take;
  logic                             pop;

  u16u8_encode u_encode (
    .code_unit (in_ch.code_unit),
    .last_unit (in_ch.last_unit),
    .max_units (max_units_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .burst     (burst)
  );

  assign pop         = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ch.ready);
  assign take        = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = cnt_r != 3'd0;
  assign out_ch.utf8_byte    = buf_r[0];
  assign out_ch.last_of_item = cnt_r == 3'd1;
  assign out_ch.end_of_text  = (cnt_r == 3'd1) && last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_units_r <= MAX_UNITS_RST;
    end else if (cfg_we) begin
      max_units_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (take) begin
      cnt_r <= burst.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // payload: load a fresh burst, or advance by one byte
  always_ff @(posedge clk) begin
    if (take) begin
      buf_r  <= burst.bytes;
      last_r <= in_ch.last_unit;
    end else if (pop) begin
      buf_r  <= {{BYTE_W{1'b0}}, buf_r[MAX_BYTES-1:1]};
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd6)
    else $error("byte count beyond six");

  a_pending_flush: assert property (@(posedge clk) disable iff (!rst_n)
    take && st_r.high_pending |=> cnt_r >= 3'd3)
    else $error("held surrogate not resolved into bytes");

  a_string_end: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_ch.last_unit |=> !st_r.high_pending && st_r.unit_index == '0
                               && cnt_r != 3'd0)
    else $error("state not cleared or no bytes after last unit");

endmodule

// ----- tb/utf16_to_utf8_transcoder_tb.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_tb
// Drives UTF-16 strings into the transcoder and checks every UTF-8 byte and
// its end flags against a cycle-free model of the conversion, including
// surrogate pairing, replacement characters, the unit limit and truncation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_tb
  import u16u8_pkg::*;
();

  localparam int QUIET_LIMIT  = 1000;
  localparam int RANDOM_UNITS = 455;

  localparam logic [CU_W-1:0] HIGH_FIRST = 16'hD800;
  localparam logic [CU_W-1:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [CU_W-1:0] LOW_FIRST  = 16'hDC00;
  localparam logic [CU_W-1:0] LOW_LAST   = 16'hDFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] utf8_byte;
    logic              last_of_item;
    logic              end_of_text;
  } utf8_out_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [CU_W-1:0]   cfg_wdata  = '0;
  logic              sink_ready = 1'b0;
  bit                idle_on    = 1'b1;
  int                errors     = 0;
  int                units_sent = 0;
  int                stall_left = 0;
  int                quiet      = 0;

  // Model state
  logic [CU_W-1:0]   limit_m;
  logic              surr_held;
  logic [HELD_W-1:0] held_bits;
  logic [CU_W-1:0]   text_pos;

  utf8_out_t         utf8_due[$];
  logic [BYTE_W-1:0] item_bytes[$];
  logic [CU_W-1:0]   text_units[$];

  u16u8_in_if  units_if ();
  u16u8_out_if bytes_if ();

  assign bytes_if.ready = sink_ready;

  utf16_to_utf8_transcoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (units_if),
    .out_ch    (bytes_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_byte(input logic [BYTE_W-1:0] b);
    item_bytes = {item_bytes, b};
  endfunction

  function automatic void emit_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      add_byte(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  // Work out the bytes one accepted code unit gives and queue them
  function automatic void encode_unit(input logic [CU_W-1:0] cu, input logic last);
    logic      taken;
    logic      is_high;
    logic      is_low;
    logic      paired;
    logic      tail;
    utf8_out_t due;
    taken   = text_pos < limit_m;
    is_high = cu >= HIGH_FIRST && cu <= HIGH_LAST;
    is_low  = cu >= LOW_FIRST && cu <= LOW_LAST;
    paired  = 1'b0;
    item_bytes = {};

    if (surr_held) begin
      surr_held = 1'b0;
      if (taken && is_low) begin
        emit_code_point(SUPP_BASE + {1'b0, held_bits, cu[9:0]});
        paired = 1'b1;
      end else begin
        emit_code_point({5'd0, REPL_CHAR});
      end
      held_bits = '0;
    end

    if (!paired) begin
      if (taken) begin
        if (is_high) begin
          // hold only while a partner can still fit under the limit
          if (!last && ({1'b0, text_pos} + 17'd1 < {1'b0, limit_m})) begin
            surr_held = 1'b1;
            held_bits = cu[9:0];
          end else begin
            emit_code_point({5'd0, REPL_CHAR});
          end
        end else if (is_low) begin
          emit_code_point({5'd0, REPL_CHAR});
        end else begin
          emit_code_point({5'd0, cu});
        end
      end else if (last) begin
        repeat (3) add_byte(DOT_BYTE);
      end
    end

    if (text_pos != INDEX_SAT) text_pos++;
    if (last) begin
      text_pos  = '0;
      surr_held = 1'b0;
      held_bits = '0;
    end

    foreach (item_bytes[i]) begin
      tail = (i == item_bytes.size() - 1);
      due  = {item_bytes[i], tail, tail && last};
      utf8_due = {utf8_due, due};
    end
  endfunction

  task automatic send_unit(input logic [CU_W-1:0] cu, input logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      units_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    units_if.valid     <= 1'b1;
    units_if.code_unit <= cu;
    units_if.last_unit <= last;
    @(posedge clk);
    while (!units_if.ready) @(posedge clk);
    units_sent++;
    encode_unit(cu, last);
  endtask

  // Drop valid and hold until every queued byte has left the block
  task automatic wait_idle();
    units_if.valid <= 1'b0;
    while (utf8_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_units(input logic [CU_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_m = value;
  endtask

  task automatic send_text();
    foreach (text_units[i]) send_unit(text_units[i], i == text_units.size() - 1);
  endtask

  function automatic void build_text(input int n);
    text_units = {};
    while (text_units.size() < n) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: text_units = {text_units, 16'($urandom_range(0, 16'h7F))};
        6, 7, 8: text_units = {text_units, 16'($urandom_range(16'h80, 16'h7FF))};
        9, 10, 11: begin
          // three-byte range with the surrogate block stepped over
          text_units = {text_units, 16'($urandom_range(16'h800, 16'hF7FF))};
          if (text_units[$] >= HIGH_FIRST) text_units[$] = text_units[$] + 16'h800;
        end
        12, 13, 14, 15: begin
          text_units = {text_units, 16'($urandom_range(HIGH_FIRST, HIGH_LAST))};
          text_units = {text_units, 16'($urandom_range(LOW_FIRST, LOW_LAST))};
        end
        16: text_units = {text_units, 16'($urandom_range(HIGH_FIRST, HIGH_LAST))};
        17: text_units = {text_units, 16'($urandom_range(LOW_FIRST, LOW_LAST))};
        default: text_units = {text_units, 16'($urandom_range(0, 16'hFFFF))};
      endcase
    end
  endfunction

  function automatic logic [CU_W-1:0] pick_max_units();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return INDEX_SAT;
      2: return MAX_UNITS_RST;
      default: return 16'($urandom_range(1, 10));
    endcase
  endfunction

  task automatic test_code_point_ranges();
    logic [CU_W-1:0] edges[7];
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFD, 16'hFFFF};
    foreach (edges[i]) send_unit(edges[i], i == 6);
  endtask

  task automatic test_surrogate_pairing();
    logic [CU_W-1:0] units[11];
    // lowest pair, highest pair, lone low, held high then ASCII,
    // high broken by high then paired, high on the last unit
    units = '{16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hDC00, 16'hD801, 16'h0041,
              16'hDA00, 16'hDB00, 16'hDC55, 16'hD834};
    foreach (units[i]) send_unit(units[i], i == 10);
  endtask

  task automatic test_unit_limit();
    wait_idle();
    set_max_units(16'd3);
    // high surrogate in the final allowed slot, then two dropped units
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0043, 1'b0);
    send_unit(16'h0044, 1'b1);
    wait_idle();
    set_max_units(16'd0);
    send_unit(16'h20AC, 1'b1);
    wait_idle();
    // held surrogate whose partner falls past a lowered limit
    set_max_units(16'd8);
    send_unit(16'hD83D, 1'b0);
    wait_idle();
    set_max_units(16'd1);
    send_unit(16'hDE00, 1'b1);
  endtask

  task automatic test_random_text();
    int base;
    base = units_sent;
    while (units_sent - base < RANDOM_UNITS) begin
      if (units_sent - base >= RANDOM_UNITS - 80) idle_on = 1'b0;
      wait_idle();
      set_max_units(pick_max_units());
      for (int s = $urandom_range(4, 10); s > 0 && units_sent - base < RANDOM_UNITS;
           s--) begin
        build_text($urandom_range(1, 12));
        send_text();
        if ($urandom_range(0, 7) == 0) wait_idle();
      end
    end
  endtask

  always @(posedge clk) begin : byte_check
    utf8_out_t seen;
    utf8_out_t want;
    if (rst_n && bytes_if.valid && bytes_if.ready) begin
      seen = {bytes_if.utf8_byte, bytes_if.last_of_item, bytes_if.end_of_text};
      if (utf8_due.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual byte %h last %b end %b",
                 $time, seen.utf8_byte, seen.last_of_item, seen.end_of_text);
        errors++;
      end else begin
        want = utf8_due.pop_front();
        if (seen.utf8_byte !== want.utf8_byte || seen.last_of_item !== want.last_of_item
            || seen.end_of_text !== want.end_of_text) begin
          $display("%0t: expected byte %h last %b end %b, actual byte %h last %b end %b",
                   $time, want.utf8_byte, want.last_of_item, want.end_of_text,
                   seen.utf8_byte, seen.last_of_item, seen.end_of_text);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      sink_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (units_if.valid && units_if.ready) || (bytes_if.valid && bytes_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    units_if.valid     <= 1'b0;
    units_if.code_unit <= '0;
    units_if.last_unit <= 1'b0;
    limit_m   = MAX_UNITS_RST;
    surr_held = 1'b0;
    held_bits = '0;
    text_pos  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_code_point_ranges();
    test_surrogate_pairing();
    test_unit_limit();
    test_random_text();

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
